// ----- sv/tsph_pkg.sv -----
// ----------------------------------------------------------------------------
// tsph_pkg
// Types and constants shared by the transport stream header parser.
// ----------------------------------------------------------------------------
package tsph_pkg;

    localparam logic [7:0] SYNC_MARK     = 8'h47;
    localparam logic [7:0] PKT_SIZE_RST  = 8'd188;

    // byte positions inside a transport packet
    localparam logic [7:0] IDX_SYNC      = 8'd0;
    localparam logic [7:0] IDX_HDR1      = 8'd1;
    localparam logic [7:0] IDX_HDR2      = 8'd2;
    localparam logic [7:0] IDX_HDR3      = 8'd3;
    localparam logic [7:0] IDX_ADAPT_LEN = 8'd4;
    localparam logic [7:0] IDX_FLAGS     = 8'd5;
    localparam logic [7:0] IDX_PCR_FIRST = 8'd6;
    localparam logic [7:0] IDX_PCR_LAST  = 8'd11;

    localparam int PCR_90K_W  = 33;
    localparam int PCR_EXT_W  = 9;
    localparam int PCR_FULL_W = 42;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       packet_start;
    } in_word_t;

    typedef struct packed {
        logic                  sync_error;
        logic                  error_bit;
        logic                  unit_start;
        logic                  priority_bit;
        logic [12:0]           pid;
        logic [1:0]            scrambling;
        logic [1:0]            field_control;
        logic [3:0]            continuity;
        logic                  has_pcr;
        logic [PCR_90K_W-1:0]  pcr_90k;
        logic [PCR_EXT_W-1:0]  pcr_ext;
        logic [PCR_FULL_W-1:0] pcr_full;
    } out_word_t;

endpackage

// ----- sv/ts_packet_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// ts_packet_header_parser_core
// Transport stream packet header and PCR extractor, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | direction | word                 | handshake
//  in      | sink      | raw byte, start      | in_valid / in_ready
//  out     | source    | header fields, PCR   | out_valid / out_ready
//  cfg     | sink      | packet_size (8 bits) | cfg_valid / cfg_ready (always ready)
//
// Takes one byte per cycle while in_ready is high; the result word for a packet
// passes through the parser register, then the PCR product register.
// Reset: packet size 188, byte position 0, all packet state cleared.
// A stalled output holds the result; the input keeps flowing until both the
// header register and the result register are full.
// ----------------------------------------------------------------------------
module ts_packet_header_parser_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tsph_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tsph_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    logic                hdr_valid;
    logic                hdr_ready;
    tsph_pkg::out_word_t hdr_data;

    assign cfg_ready = 1'b1;

    tsph_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr_data  (hdr_data)
    );

    tsph_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr_data  (hdr_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- sv/tsph_parser.sv -----
// ----------------------------------------------------------------------------
// tsph_parser
// Per-byte header field capture; emits one header word per packet.
// ----------------------------------------------------------------------------
module tsph_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tsph_pkg::in_word_t in_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    output logic               hdr_valid,
    input  logic               hdr_ready,
    output tsph_pkg::out_word_t hdr_data
);

    logic [7:0]  packet_size_reg;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [23:0] header_reg, header_next;
    logic [7:0]  adapt_len_reg, adapt_len_next;
    logic        pcr_seen_reg, pcr_seen_next;
    logic [47:0] pcr_shift_reg, pcr_shift_next;
    logic        sync_bad_reg, sync_bad_next;

    logic        hdr_valid_reg;
    tsph_pkg::out_word_t hdr_data_reg, hdr_data_next;

    logic        accept;
    logic [7:0]  idx;
    logic        last_byte;
    logic [7:0]  b;

    assign in_ready = !hdr_valid_reg || hdr_ready;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.raw_byte;
    assign idx      = in_data.packet_start ? tsph_pkg::IDX_SYNC : byte_index_reg;
    assign last_byte = ({1'b0, idx} + 9'd1) >= {1'b0, packet_size_reg};

    always_comb
    begin
        header_next    = header_reg;
        adapt_len_next = adapt_len_reg;
        pcr_seen_next  = pcr_seen_reg;
        pcr_shift_next = pcr_shift_reg;
        sync_bad_next  = sync_bad_reg;

        if (idx == tsph_pkg::IDX_SYNC)
        begin
            header_next    = '0;
            adapt_len_next = '0;
            pcr_seen_next  = 1'b0;
            pcr_shift_next = '0;
            sync_bad_next  = (b != tsph_pkg::SYNC_MARK);
        end
        else if (idx == tsph_pkg::IDX_HDR1)
        begin
            header_next[23:16] = header_reg[23:16] | b;
        end
        else if (idx == tsph_pkg::IDX_HDR2)
        begin
            header_next[15:8] = header_reg[15:8] | b;
        end
        else if (idx == tsph_pkg::IDX_HDR3)
        begin
            header_next[7:0] = header_reg[7:0] | b;
        end
        else if (idx == tsph_pkg::IDX_ADAPT_LEN)
        begin
            if (header_reg[5])
                adapt_len_next = b;
        end
        else if (idx == tsph_pkg::IDX_FLAGS)
        begin
            if (header_reg[5] && (adapt_len_reg != 8'd0))
                pcr_seen_next = b[4];
        end
        else if (idx inside {[tsph_pkg::IDX_PCR_FIRST:tsph_pkg::IDX_PCR_LAST]})
        begin
            if (pcr_seen_reg)
                pcr_shift_next = {pcr_shift_reg[39:0], b};
        end

        byte_index_next = last_byte ? tsph_pkg::IDX_SYNC : idx + 8'd1;

        // build the header word from the updated state
        hdr_data_next = '0;
        if (sync_bad_next)
        begin
            hdr_data_next.sync_error = 1'b1;
        end
        else
        begin
            hdr_data_next.error_bit     = header_next[23];
            hdr_data_next.unit_start    = header_next[22];
            hdr_data_next.priority_bit  = header_next[21];
            hdr_data_next.pid           = header_next[20:8];
            hdr_data_next.scrambling    = header_next[7:6];
            hdr_data_next.field_control = header_next[5:4];
            hdr_data_next.continuity    = header_next[3:0];
            if (pcr_seen_next && idx >= tsph_pkg::IDX_PCR_LAST)
            begin
                hdr_data_next.has_pcr  = 1'b1;
                hdr_data_next.pcr_90k  = pcr_shift_next[47:15];
                hdr_data_next.pcr_ext  = pcr_shift_next[8:0];
            end
        end
        // product is filled in downstream
        hdr_data_next.pcr_full = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_size_reg <= tsph_pkg::PKT_SIZE_RST;
            byte_index_reg  <= '0;
            header_reg      <= '0;
            adapt_len_reg   <= '0;
            pcr_seen_reg    <= 1'b0;
            pcr_shift_reg   <= '0;
            sync_bad_reg    <= 1'b0;
            hdr_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                packet_size_reg <= cfg_data;
            if (accept)
            begin
                byte_index_reg <= byte_index_next;
                header_reg     <= header_next;
                adapt_len_reg  <= adapt_len_next;
                pcr_seen_reg   <= pcr_seen_next;
                pcr_shift_reg  <= pcr_shift_next;
                sync_bad_reg   <= sync_bad_next;
            end
            if (accept && last_byte)
                hdr_valid_reg <= 1'b1;
            else if (hdr_ready)
                hdr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
            hdr_data_reg <= hdr_data_next;
    end

    assign hdr_valid = hdr_valid_reg;
    assign hdr_data  = hdr_data_reg;

`ifndef ASSERT_OFF
    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.packet_start) |=> (byte_index_reg <= 8'd1))
        else $error("start mark did not restart the byte position");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg != 8'hFF)
        else $error("byte position ran past the largest packet size");

    a_hdr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_valid_reg && !hdr_ready) |=> (hdr_valid_reg && $stable(hdr_data_reg)))
        else $error("header word dropped or changed while stalled");
`endif

endmodule

// ----- sv/tsph_out_stage.sv -----
// ----------------------------------------------------------------------------
// tsph_out_stage
// Forms the 27 MHz PCR count and holds the result word for the sink.
// ----------------------------------------------------------------------------
module tsph_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hdr_valid,
    output logic                hdr_ready,
    input  tsph_pkg::out_word_t hdr_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tsph_pkg::out_word_t out_data
);

    logic                out_valid_reg;
    tsph_pkg::out_word_t out_data_reg, out_data_next;
    logic [tsph_pkg::PCR_FULL_W-1:0] base_w;

    assign hdr_ready = !out_valid_reg || out_ready;

    // base * 300 as base * (256 + 32 + 8 + 4)
    assign base_w = {{(tsph_pkg::PCR_FULL_W - tsph_pkg::PCR_90K_W){1'b0}},
                     hdr_data.pcr_90k};

    always_comb
    begin
        out_data_next = hdr_data;
        out_data_next.pcr_full = (base_w << 8) + (base_w << 5) + (base_w << 3)
                               + (base_w << 2)
                               + {{(tsph_pkg::PCR_FULL_W - tsph_pkg::PCR_EXT_W){1'b0}},
                                  hdr_data.pcr_ext};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (hdr_ready)
            out_valid_reg <= hdr_valid;
    end

    always_ff @(posedge clk)
    begin
        if (hdr_valid && hdr_ready)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_sync_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.sync_error) |->
            (out_data_reg.pid == 13'd0 && !out_data_reg.has_pcr))
        else $error("sync error word carries header fields");

    a_no_pcr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.has_pcr) |-> (out_data_reg.pcr_full == '0))
        else $error("PCR count set without a PCR");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("result word changed while stalled");
`endif

endmodule
